>>> src/rts_pkg.sv
// Shared types, codes and helpers of the RTF token scanner.
`default_nettype none

package rts_pkg;

  localparam int RTS_MAX_NAME = 32;
  localparam int RTS_OUT_TDATA_W = 48;
  localparam int RTS_ACC_W = 31;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [4:0] HEX_BAD = 5'd16;

  // Largest accumulator that still takes one more digit without passing 2^31-1.
  localparam logic [RTS_ACC_W-1:0] DIG_LIM_LO = 31'd214748364;
  localparam logic [RTS_ACC_W-1:0] DIG_LIM_HI = 31'd214748363;

  typedef enum logic [2:0] {
    K_GOPEN  = 3'd0,
    K_GCLOSE = 3'd1,
    K_TEXT   = 3'd2,
    K_NAME   = 3'd3,
    K_WEND   = 3'd4,
    K_SYMBOL = 3'd5,
    K_HEX    = 3'd6,
    K_EOF    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CS_ZERO = 2'd0,
    CS_BYTE = 2'd1,
    CS_HEX  = 2'd2,
    CS_NAME = 2'd3
  } char_sel_t;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_TEXT   = 4'd1,
    M_ESC    = 4'd2,
    M_NAME   = 4'd3,
    M_SIGN   = 4'd4,
    M_DIGITS = 4'd5,
    M_HEX1   = 4'd6,
    M_HEX2   = 4'd7,
    M_SKIP   = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    P_IN    = 3'd0,
    P_FLUSH = 3'd1,
    P_WEND  = 3'd2,
    P_REDO  = 3'd3,
    P_EOF   = 3'd4
  } phase_t;

  typedef struct packed {
    logic      use_latched;
    logic      accept;
    logic      emit;
    kind_t     kind;
    char_sel_t char_sel;
    logic      tstart;
    logic      last;
    logic      first_letter;
    logic      store_letter;
    logic      set_neg;
    logic      add_digit;
    logic      clear_word;
    logic      load_hex1;
    logic      load_skip;
    logic      dec_skip;
    logic      start_flush;
    logic      flush_adv;
    logic      reset_all;
  } rts_cmd_t;

  typedef struct packed {
    logic is_crlf;
    logic is_lbrace;
    logic is_rbrace;
    logic is_bslash;
    logic is_letter;
    logic is_digit;
    logic is_minus;
    logic is_quote;
    logic is_space;
    logic fin;
    logic is_bin;
    logic val_pos;
    logic acc_one;
    logic skip_le1;
    logic flush_last;
    logic idx_zero;
    logic out_free;
  } rts_stat_t;

  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = HEX_BAD;
    if (c inside {[CH_0:CH_9]}) begin
      r = 5'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
      r = 5'(c - CH_LA + 8'd10);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = 5'(c - CH_UA + 8'd10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/rts_ctrl.sv
// Controller: scan mode and result sequencing state machines.
`default_nettype none

module rts_ctrl
  import rts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rts_stat_t st,
  output rts_cmd_t       cmd
);

  mode_t     mode, mode_next;
  phase_t    phase, phase_next;

  logic      ih_res;
  kind_t     ih_kind;
  char_sel_t ih_csel;
  logic      ih_clr;
  mode_t     ih_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      phase <= P_IN;
    end else begin
      mode  <= mode_next;
      phase <= phase_next;
    end
  end

  // Between-tokens handling of the current byte.
  always_comb begin
    ih_res  = 1'b0;
    ih_kind = K_TEXT;
    ih_csel = CS_ZERO;
    ih_clr  = 1'b0;
    ih_mode = M_IDLE;
    if (st.is_crlf) begin
      ih_mode = M_IDLE;
    end else if (st.is_lbrace) begin
      ih_res  = 1'b1;
      ih_kind = K_GOPEN;
    end else if (st.is_rbrace) begin
      ih_res  = 1'b1;
      ih_kind = K_GCLOSE;
    end else if (st.is_bslash) begin
      ih_clr  = 1'b1;
      ih_mode = M_ESC;
    end else begin
      ih_res  = 1'b1;
      ih_kind = K_TEXT;
      ih_csel = CS_BYTE;
      ih_mode = M_TEXT;
    end
  end

  always_comb begin
    logic      res;
    kind_t     kind;
    char_sel_t csel;
    logic      ts;
    mode_t     mnext;
    logic      flush;
    logic      eof_need;
    logic      rres;
    mode_t     rmode;

    res      = 1'b0;
    kind     = K_TEXT;
    csel     = CS_ZERO;
    ts       = 1'b1;
    mnext    = mode;
    flush    = 1'b0;
    eof_need = 1'b0;
    rres     = 1'b0;
    rmode    = M_IDLE;

    cmd             = '0;
    cmd.use_latched = (phase != P_IN);
    mode_next       = mode;
    phase_next      = phase;
    in_ready        = (phase == P_IN) && st.out_free;

    case (phase)
      P_IN: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          case (mode)
            M_IDLE: begin
              res            = ih_res;
              kind           = ih_kind;
              csel           = ih_csel;
              mnext          = ih_mode;
              cmd.clear_word = ih_clr;
            end
            M_TEXT: begin
              if (st.is_crlf || st.is_lbrace || st.is_rbrace || st.is_bslash) begin
                res            = ih_res;
                kind           = ih_kind;
                csel           = ih_csel;
                mnext          = ih_mode;
                cmd.clear_word = ih_clr;
              end else begin
                res  = 1'b1;
                kind = K_TEXT;
                csel = CS_BYTE;
                ts   = 1'b0;
              end
            end
            M_ESC: begin
              if (st.is_letter) begin
                cmd.first_letter = 1'b1;
                mnext            = M_NAME;
              end else if (st.is_quote) begin
                mnext = M_HEX1;
              end else begin
                res   = 1'b1;
                kind  = K_SYMBOL;
                csel  = CS_BYTE;
                mnext = M_IDLE;
              end
            end
            M_NAME, M_SIGN, M_DIGITS: begin
              if (mode == M_NAME && st.is_letter) begin
                cmd.store_letter = 1'b1;
              end else if (mode == M_NAME && st.is_minus) begin
                cmd.set_neg = 1'b1;
                mnext       = M_SIGN;
              end else if (st.is_digit) begin
                cmd.add_digit = 1'b1;
                mnext         = M_DIGITS;
              end else if (st.is_bin) begin
                if (st.val_pos) begin
                  cmd.load_skip = 1'b1;
                  mnext = (!st.is_space && st.acc_one) ? M_IDLE : M_SKIP;
                end else if (st.is_space) begin
                  mnext = M_IDLE;
                end else begin
                  res            = ih_res;
                  kind           = ih_kind;
                  csel           = ih_csel;
                  mnext          = ih_mode;
                  cmd.clear_word = ih_clr;
                end
              end else begin
                flush = 1'b1;
              end
            end
            M_HEX1: begin
              cmd.load_hex1 = 1'b1;
              mnext         = M_HEX2;
            end
            M_HEX2: begin
              res   = 1'b1;
              kind  = K_HEX;
              csel  = CS_HEX;
              mnext = M_IDLE;
            end
            M_SKIP: begin
              cmd.dec_skip = 1'b1;
              if (st.skip_le1) begin
                mnext = M_IDLE;
              end
            end
            default: begin
              mnext = M_IDLE;
            end
          endcase

          if (flush) begin
            cmd.start_flush = 1'b1;
            phase_next      = P_FLUSH;
          end else begin
            eof_need = st.fin && (mnext != M_IDLE);
            if (st.fin) begin
              cmd.reset_all = 1'b1;
              mode_next     = M_IDLE;
            end else begin
              mode_next = mnext;
            end
            if (res) begin
              cmd.emit     = 1'b1;
              cmd.kind     = kind;
              cmd.char_sel = csel;
              cmd.tstart   = ts;
              cmd.last     = !eof_need;
              if (eof_need) begin
                phase_next = P_EOF;
              end
            end else if (eof_need) begin
              cmd.emit     = 1'b1;
              cmd.kind     = K_EOF;
              cmd.char_sel = CS_ZERO;
              cmd.tstart   = 1'b0;
              cmd.last     = 1'b1;
            end
          end
        end
      end
      P_FLUSH: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = K_NAME;
          cmd.char_sel  = CS_NAME;
          cmd.tstart    = st.idx_zero;
          cmd.flush_adv = 1'b1;
          if (st.flush_last) begin
            phase_next = P_WEND;
          end
        end
      end
      P_WEND: begin
        if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = K_WEND;
          cmd.char_sel   = CS_ZERO;
          cmd.clear_word = 1'b1;
          if (!st.is_space) begin
            rres  = ih_res;
            rmode = ih_mode;
          end
          if (rres) begin
            phase_next = P_REDO;
          end else begin
            eof_need = st.fin && (rmode != M_IDLE);
            cmd.last = !eof_need;
            if (st.fin) begin
              cmd.reset_all = 1'b1;
              mode_next     = M_IDLE;
            end else begin
              mode_next = rmode;
            end
            phase_next = eof_need ? P_EOF : P_IN;
          end
        end
      end
      P_REDO: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = ih_kind;
          cmd.char_sel = ih_csel;
          cmd.tstart   = 1'b1;
          eof_need     = st.fin && (ih_mode != M_IDLE);
          cmd.last     = !eof_need;
          if (st.fin) begin
            cmd.reset_all = 1'b1;
            mode_next     = M_IDLE;
          end else begin
            mode_next = ih_mode;
          end
          phase_next = eof_need ? P_EOF : P_IN;
        end
      end
      P_EOF: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = K_EOF;
          cmd.char_sel = CS_ZERO;
          cmd.last     = 1'b1;
          phase_next   = P_IN;
        end
      end
      default: begin
        phase_next = P_IN;
        mode_next  = M_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/rts_datapath.sv
// Datapath: byte classing, name store, parameter accumulator and result register.
`default_nettype none

module rts_datapath
  import rts_pkg::*;
#(
  parameter int MAX_NAME = RTS_MAX_NAME
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rts_cmd_t                    cmd,
  output rts_stat_t                        st,
  input  wire logic [7:0]                  in_byte,
  input  wire logic                        in_fin,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [RTS_OUT_TDATA_W-1:0]       out_data,
  output logic [2:0]                       out_kind,
  output logic                             out_last
);

  localparam int IW = $clog2(MAX_NAME);
  localparam int LW = $clog2(MAX_NAME + 1);
  localparam int PAD_W = RTS_OUT_TDATA_W - 42;

  logic [6:0]           name_mem [MAX_NAME];
  logic [6:0]           rd_data;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        idx;

  logic [7:0]           c_reg;
  logic                 fin_reg;
  logic [LW-1:0]        len;
  logic [RTS_ACC_W-1:0] acc;
  logic                 neg;
  logic                 digits;
  logic                 ovf;
  logic                 bin_ok;
  logic [7:0]           hex1;
  logic [RTS_ACC_W-1:0] skip_rem;

  logic [7:0]           cur;
  logic [3:0]           dval;
  logic [RTS_ACC_W-1:0] dig_lim;
  logic [RTS_ACC_W-1:0] acc_x10;
  logic [4:0]           hi_nib;
  logic [4:0]           lo_nib;
  logic [7:0]           hex_val;
  logic [31:0]          mag;
  logic [31:0]          param;
  logic [7:0]           ch;
  logic                 len_room;
  logic                 bin_step;

  assign cur = cmd.use_latched ? c_reg : in_byte;

  always_comb begin
    st            = '0;
    st.is_crlf    = (cur == CH_LF) || (cur == CH_CR);
    st.is_lbrace  = (cur == CH_LBRACE);
    st.is_rbrace  = (cur == CH_RBRACE);
    st.is_bslash  = (cur == CH_BSLASH);
    st.is_letter  = (cur inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]});
    st.is_digit   = (cur inside {[CH_0:CH_9]});
    st.is_minus   = (cur == CH_MINUS);
    st.is_quote   = (cur == CH_QUOTE);
    st.is_space   = (cur == CH_SPACE);
    st.fin        = cmd.use_latched ? fin_reg : in_fin;
    st.is_bin     = bin_ok && (len == LW'(3));
    st.val_pos    = !neg && !ovf && (acc != '0);
    st.acc_one    = (acc == RTS_ACC_W'(1));
    st.skip_le1   = (skip_rem <= RTS_ACC_W'(1));
    st.flush_last = ((LW'(idx) + LW'(1)) == len);
    st.idx_zero   = (idx == '0);
    st.out_free   = !out_valid || out_ready;
  end

  assign dval     = 4'(cur - CH_0);
  assign dig_lim  = (dval >= 4'd8) ? DIG_LIM_HI : DIG_LIM_LO;
  assign acc_x10  = {acc[RTS_ACC_W-4:0], 3'b000} + {acc[RTS_ACC_W-2:0], 1'b0}
                  + RTS_ACC_W'(dval);
  assign len_room = (len < LW'(MAX_NAME));
  assign bin_step = ((len == LW'(1)) && (cur == CH_I)) || ((len == LW'(2)) && (cur == CH_N));

  assign hi_nib  = hex_nib(hex1);
  assign lo_nib  = hex_nib(cur);
  assign hex_val = (hi_nib[4] || lo_nib[4]) ? 8'h00 : {hi_nib[3:0], lo_nib[3:0]};

  assign mag   = ovf ? 32'd0 : {1'b0, acc};
  assign param = neg ? (32'd0 - mag) : mag;

  always_comb begin
    case (cmd.char_sel)
      CS_BYTE: ch = cur;
      CS_HEX:  ch = hex_val;
      CS_NAME: ch = {1'b0, rd_data};
      default: ch = 8'h00;
    endcase
  end

  always_comb begin
    if (cmd.start_flush) begin
      rd_addr = '0;
    end else if (cmd.flush_adv) begin
      rd_addr = IW'(idx + 1'b1);
    end else begin
      rd_addr = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first_letter) begin
      name_mem[0] <= cur[6:0];
    end else if (cmd.store_letter && len_room) begin
      name_mem[len[IW-1:0]] <= cur[6:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= name_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_reg   <= in_byte;
      fin_reg <= in_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.start_flush) begin
      idx <= '0;
    end else if (cmd.flush_adv) begin
      idx <= IW'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_all || cmd.clear_word) begin
      len    <= '0;
      acc    <= '0;
      neg    <= 1'b0;
      digits <= 1'b0;
      ovf    <= 1'b0;
      bin_ok <= 1'b0;
    end else begin
      if (cmd.first_letter) begin
        len    <= LW'(1);
        bin_ok <= (cur == CH_B);
      end else if (cmd.store_letter && len_room) begin
        len    <= len + LW'(1);
        bin_ok <= bin_ok && bin_step;
      end
      if (cmd.set_neg) begin
        neg <= 1'b1;
      end
      if (cmd.add_digit) begin
        digits <= 1'b1;
        if (!ovf) begin
          if (acc > dig_lim) begin
            ovf <= 1'b1;
          end else begin
            acc <= acc_x10;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_all) begin
      hex1     <= '0;
      skip_rem <= '0;
    end else begin
      if (cmd.load_hex1) begin
        hex1 <= cur;
      end
      if (cmd.load_skip) begin
        skip_rem <= st.is_space ? acc : acc - RTS_ACC_W'(1);
      end else if (cmd.dec_skip && (skip_rem != '0)) begin
        skip_rem <= skip_rem - RTS_ACC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_last <= cmd.last;
      out_data <= {PAD_W'(0),
                   (cmd.kind == K_WEND) ? digits : 1'b0,
                   (cmd.kind == K_WEND) ? param : 32'd0,
                   cmd.tstart,
                   ch};
    end
  end

endmodule

`default_nettype wire

>>> src/rtf_token_scanner_top.sv
// Top level of the RTF token scanner: stream ports, controller and datapath.
//
// Takes one RTF byte per transaction on the slave side and gives token results on the
// master side, one result per transaction, tlast marking the final result of an input byte.
// A byte that gives at most one result, and needs no end-of-stream error after it, or that
// ends a bin word, is complete once taken. A byte that ends a control word other than bin
// is taken first, then gives one result per stored name letter and one for the word end,
// plus one more if the delimiter gives a result of its own. An end-of-stream error comes
// after any other result of the same byte. The single output register holds one result per
// cycle and the name store is read one letter per cycle, while that register is free or
// taken; the scanner stalls while it is full and not taken, and takes no new byte until all
// results of the last one are issued. No clearing pass follows reset.
`default_nettype none

module rtf_token_scanner_top
  import rts_pkg::*;
#(
  parameter int MAX_NAME = RTS_MAX_NAME
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // data_byte
  input  wire logic                        s_axis_tlast,  // final_byte
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // char_value[7:0], token_start[8], param_value[40:9], has_param[41], zero[47:42]
  output logic [RTS_OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,  // kind
  output logic                             m_axis_tlast   // last_of_run
);

  rts_cmd_t  cmd;
  rts_stat_t st;

  rts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rts_datapath #(
    .MAX_NAME (MAX_NAME)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_byte   (s_axis_tdata),
    .in_fin    (s_axis_tlast),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> sim/rtf_token_scanner_top_tb.sv
// Self-checking testbench for the RTF token scanner: directed and random byte streams.
module rtf_token_scanner_top_tb;
  import rts_pkg::*;

  localparam int MAX_RES        = RTS_MAX_NAME + 3;
  localparam int RANDOM_BYTES   = 60;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} rx_mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  chr;
    logic        start;
    logic [31:0] param;
    logic        has_p;
    logic        last;
  } token_res_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = 8'h00;
  logic                       s_axis_tlast = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [RTS_OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]                 m_axis_tuser;
  logic                       m_axis_tlast;

  rtf_token_scanner_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Scanner image kept in step with the accepted bytes.
  mode_t       scan_st = M_IDLE;
  logic [6:0]  name_buf [RTS_MAX_NAME];
  int          name_len = 0;
  logic [31:0] acc = '0;
  logic        neg = 1'b0;
  logic        dig = 1'b0;
  logic        ovf = 1'b0;
  logic [7:0]  hex_hi = '0;
  logic [31:0] skip_cnt = '0;

  token_res_t  run_res[$];
  token_res_t  exp_tokens[$];
  logic [7:0]  tok_q[$];

  int          errors = 0;
  int          idle_cycles = 0;
  int          tx_burst = 0;
  bit          tx_gappy = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_tick = 0;

  function automatic bit is_alpha(input logic [7:0] c);
    return ((c | 8'h20) >= CH_LA) && ((c | 8'h20) <= CH_LZ);
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return {1'b0, c[3:0]};
    if ((c | 8'h20) >= CH_LA && (c | 8'h20) <= CH_LF_HEX) return 5'(c[3:0] + 4'd9);
    return HEX_BAD;
  endfunction

  function automatic void add_res(input kind_t k, input logic [7:0] ch, input logic ts,
                                  input logic [31:0] pv, input logic hp);
    token_res_t r;
    r.kind  = k;
    r.chr   = ch;
    r.start = ts;
    r.param = pv;
    r.has_p = hp;
    r.last  = 1'b0;
    if (run_res.size() < MAX_RES) run_res.push_back(r);
  endfunction

  function automatic void clear_word();
    name_len = 0;
    acc      = '0;
    neg      = 1'b0;
    dig      = 1'b0;
    ovf      = 1'b0;
  endfunction

  function automatic void reset_scanner();
    scan_st = M_IDLE;
    clear_word();
    hex_hi   = '0;
    skip_cnt = '0;
  endfunction

  task automatic close_word(input logic [7:0] c, output bit redo);
    logic [31:0] v;
    v = ovf ? 32'd0 : acc;
    if (neg) v = -v;
    redo    = (c != CH_SPACE);
    scan_st = M_IDLE;
    if (name_len == 3 && {1'b0, name_buf[0]} == CH_B && {1'b0, name_buf[1]} == CH_I &&
        {1'b0, name_buf[2]} == CH_N) begin
      if (v != 0 && !v[31]) begin
        skip_cnt = (c == CH_SPACE) ? v : v - 32'd1;
        scan_st  = (skip_cnt != 0) ? M_SKIP : M_IDLE;
        redo     = 1'b0;
      end
    end else begin
      for (int i = 0; i < name_len; i++) begin
        add_res(K_NAME, {1'b0, name_buf[i]}, i == 0, 32'd0, 1'b0);
      end
      add_res(K_WEND, 8'h00, 1'b0, v, dig);
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic fin);
    bit          again;
    logic [4:0]  hi;
    logic [4:0]  lo;
    logic [31:0] dg;
    token_res_t  r;
    run_res.delete();
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (scan_st)
        M_IDLE: begin
          if (c == CH_LF || c == CH_CR) begin
          end else if (c == CH_LBRACE) begin
            add_res(K_GOPEN, 8'h00, 1'b1, 32'd0, 1'b0);
          end else if (c == CH_RBRACE) begin
            add_res(K_GCLOSE, 8'h00, 1'b1, 32'd0, 1'b0);
          end else if (c == CH_BSLASH) begin
            clear_word();
            scan_st = M_ESC;
          end else begin
            add_res(K_TEXT, c, 1'b1, 32'd0, 1'b0);
            scan_st = M_TEXT;
          end
        end
        M_TEXT: begin
          if (c == CH_BSLASH || c == CH_LBRACE || c == CH_RBRACE || c == CH_LF ||
              c == CH_CR) begin
            scan_st = M_IDLE;
            again   = 1'b1;
          end else begin
            add_res(K_TEXT, c, 1'b0, 32'd0, 1'b0);
          end
        end
        M_ESC: begin
          if (is_alpha(c)) begin
            name_buf[0] = c[6:0];
            name_len    = 1;
            scan_st     = M_NAME;
          end else if (c == CH_QUOTE) begin
            scan_st = M_HEX1;
          end else begin
            add_res(K_SYMBOL, c, 1'b1, 32'd0, 1'b0);
            scan_st = M_IDLE;
          end
        end
        M_NAME, M_SIGN, M_DIGITS: begin
          if (scan_st == M_NAME && is_alpha(c)) begin
            if (name_len < RTS_MAX_NAME) begin
              name_buf[name_len] = c[6:0];
              name_len++;
            end
          end else if (scan_st == M_NAME && c == CH_MINUS) begin
            neg     = 1'b1;
            scan_st = M_SIGN;
          end else if (c >= CH_0 && c <= CH_9) begin
            dg  = 32'(c - CH_0);
            dig = 1'b1;
            if (!ovf) begin
              if (acc > (32'h7FFF_FFFF - dg) / 32'd10) ovf = 1'b1;
              else acc = acc * 32'd10 + dg;
            end
            scan_st = M_DIGITS;
          end else begin
            close_word(c, again);
          end
        end
        M_HEX1: begin
          hex_hi  = c;
          scan_st = M_HEX2;
        end
        M_HEX2: begin
          hi = hex_digit(hex_hi);
          lo = hex_digit(c);
          add_res(K_HEX, (hi < 16 && lo < 16) ? {hi[3:0], lo[3:0]} : 8'h00, 1'b1, 32'd0, 1'b0);
          scan_st = M_IDLE;
        end
        M_SKIP: begin
          if (skip_cnt != 0) skip_cnt = skip_cnt - 32'd1;
          if (skip_cnt == 0) scan_st = M_IDLE;
        end
        default: scan_st = M_IDLE;
      endcase
    end
    if (fin) begin
      if (scan_st != M_IDLE) add_res(K_EOF, 8'h00, 1'b0, 32'd0, 1'b0);
      reset_scanner();
    end
    if (run_res.size() > 0) begin
      r = run_res.pop_back();
      r.last = 1'b1;
      run_res.push_back(r);
    end
    foreach (run_res[i]) exp_tokens.push_back(run_res[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (tx_burst == 0) begin
      gap = tx_gappy ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_burst = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_tokens(b, fin);
    tx_burst--;
  endtask

  task automatic push_byte(input logic [7:0] b);
    tok_q.push_back(b);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) tok_q.push_back(s[i]);
  endtask

  task automatic flush_bytes(input bit fin_last, input int fin_odds);
    logic f;
    for (int i = 0; i < tok_q.size(); i++) begin
      f = (fin_last && i == tok_q.size() - 1) ||
          (fin_odds != 0 && $urandom_range(1, fin_odds) == 1);
      send_byte(tok_q[i], f);
    end
    tok_q.delete();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    tx_burst = 0;
  endtask

  function automatic logic [7:0] rand_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'(CH_LA + k) : 8'(CH_UA + k - 26);
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] t;
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
    t = 8'($urandom_range(32, 126));
    if (t == CH_BSLASH || t == CH_LBRACE || t == CH_RBRACE) t = CH_N;
    return t;
  endfunction

  task automatic test_groups_and_text();
    rx_mode  = RX_OPEN;
    tx_gappy = 1'b0;
    push_str("{Ab");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("}");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_str("{x");
    push_byte(CH_LF);
    push_str("}");
    flush_bytes(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_control_words();
    rx_mode  = RX_COMB;
    tx_gappy = 1'b1;
    push_str("\\par \\b0\\i-12}\\fs-{\\ul\\x ");
    flush_bytes(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_param_extremes();
    rx_mode  = RX_COIN;
    tx_gappy = 1'b1;
    push_str("\\up2147483647 \\dn2147483648 \\li-2147483647\\ri99999999999 ");
    flush_bytes(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_long_name();
    rx_mode  = RX_TRICKLE;
    tx_gappy = 1'b0;
    push_str("\\abcdefghijklmnopqrstuvwxyzABCDEFGHZ7}");
    flush_bytes(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_symbols_and_hex();
    rx_mode  = RX_COMB;
    tx_gappy = 1'b1;
    push_str("\\~\\{\\'4f\\'A0\\'g1\\'1z\\'Ff\\\\\\");
    push_byte(8'hFF);
    flush_bytes(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_bin_skip();
    rx_mode  = RX_COIN;
    tx_gappy = 1'b1;
    push_str("\\bin3 ");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("\\\\bin2}{t\\bin1x\\bin0 q\\bin-1{\\bin{\\bin2147483648 }");
    flush_bytes(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_unexpected_end();
    rx_mode  = RX_OPEN;
    tx_gappy = 1'b1;
    push_str("ab");       flush_bytes(1'b1, 0);
    push_str("\\par");    flush_bytes(1'b1, 0);
    push_str("\\bin4 xy"); flush_bytes(1'b1, 0);
    push_str("\\'4");     flush_bytes(1'b1, 0);
    push_str("\\");       flush_bytes(1'b1, 0);
    push_str("\\b12");    flush_bytes(1'b1, 0);
    push_str("{}");       flush_bytes(1'b1, 0);
    push_str("\\par ");   flush_bytes(1'b1, 0);
    push_str("\\'4f");    flush_bytes(1'b1, 0);
    push_str("\\parx");   flush_bytes(1'b0, 0);
    push_str("\\par");    flush_bytes(1'b0, 0);
    push_str("d1x");      flush_bytes(1'b1, 0);
    wait_drained();
  endtask

  task automatic gen_random_token();
    int    n;
    string hex_chars;
    hex_chars = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 11))
      0: push_byte(CH_LBRACE);
      1: push_byte(CH_RBRACE);
      2, 3: begin
        n = $urandom_range(1, 8);
        repeat (n) push_byte(rand_text());
      end
      4: push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      5, 6: begin
        push_byte(CH_BSLASH);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        repeat (n) push_byte(rand_letter());
        if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS);
        case ($urandom_range(0, 5))
          0: ;
          1, 2: push_str($sformatf("%0d", $urandom_range(0, 999)));
          3: push_str($sformatf("%0d", $urandom));
          4: push_str("2147483647");
          default: push_str($sformatf("%0d", 64'd2147483648 + 64'($urandom_range(0, 99999))));
        endcase
        case ($urandom_range(0, 5))
          0, 1, 2: push_byte(CH_SPACE);
          3: push_byte(CH_LBRACE);
          4: push_byte(CH_RBRACE);
          default: push_byte(rand_text());
        endcase
      end
      7: begin
        push_byte(CH_BSLASH);
        push_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h7E);
      end
      8: begin
        push_str("\\'");
        repeat (2) begin
          if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
          else push_byte(hex_chars[$urandom_range(0, 21)]);
        end
      end
      9: begin
        push_str("\\bin");
        n = $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0) push_byte(CH_MINUS);
        push_str($sformatf("%0d", n));
        push_byte($urandom_range(0, 2) != 0 ? CH_SPACE : 8'($urandom_range(0, 255)));
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic test_random_streams();
    int sent;
    int seg_end;
    bit paused;
    sent    = 0;
    seg_end = 0;
    paused  = 1'b0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= seg_end) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        tx_gappy = ($urandom_range(0, 3) != 0);
        seg_end  = sent + 50;
      end
      if (!paused && sent >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      gen_random_token();
      sent += tok_q.size();
      flush_bytes($urandom_range(0, 19) == 0, 80);
    end
    wait_drained();
  endtask

  task automatic check_field(input string what, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    token_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_tokens.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d tdata %h", $time,
                 m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = exp_tokens.pop_front();
        check_field("kind", 48'(want.kind), 48'(m_axis_tuser));
        check_field("char_value", 48'(want.chr), 48'(m_axis_tdata[7:0]));
        check_field("token_start", 48'(want.start), 48'(m_axis_tdata[8]));
        check_field("param_value", 48'(want.param), 48'(m_axis_tdata[40:9]));
        check_field("has_param", 48'(want.has_p), 48'(m_axis_tdata[41]));
        check_field("pad", 48'd0, 48'(m_axis_tdata[47:42]));
        check_field("last_of_run", 48'(want.last), 48'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN: m_axis_tready <= 1'b1;
      RX_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_COMB: m_axis_tready <= ((rx_tick % 11) > 3);
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_groups_and_text();
    test_control_words();
    test_param_extremes();
    test_long_name();
    test_symbols_and_hex();
    test_bin_skip();
    test_unexpected_end();
    test_random_streams();
    if (errors == 0 && exp_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rts_pkg.sv
src/rts_ctrl.sv
src/rts_datapath.sv
src/rtf_token_scanner_top.sv
sim/rtf_token_scanner_top_tb.sv
